// ===== rtl/core/efpt_pkg.sv =====
// Package for the encoder frame position tracker.
// Holds the shared widths, codes, request and length tables and the record types.
// No dependencies; every other file of the block imports it.
package efpt_pkg;

  localparam int POSITION_BITS = 17;
  localparam int FRAME_BYTES   = 11;

  localparam int POS_W   = POSITION_BITS;
  localparam int CNT_W   = $clog2(FRAME_BYTES + 1);
  localparam int IDX_W   = $clog2(FRAME_BYTES);
  localparam int WAIT_W  = 17;
  localparam int PORT_POS_W = 17;
  localparam int MUL_W   = POS_W + 8;
  localparam int TOTAL_W = 32;

  typedef enum logic [1:0] {
    CMD_TICK      = 2'd0,
    CMD_BYTE      = 2'd1,
    CMD_LINE_IDLE = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    KIND_REQUEST = 2'd0,
    KIND_DECODED = 2'd1,
    KIND_SHORT   = 2'd2,
    KIND_TIMEOUT = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ID_0 = 3'd0,
    ID_1 = 3'd1,
    ID_2 = 3'd2,
    ID_3 = 3'd3,
    ID_7 = 3'd4,
    ID_8 = 3'd5,
    ID_C = 3'd6
  } data_id_t;

  typedef enum logic [1:0] {
    REG_REQUEST_ID  = 2'd0,
    REG_PAIR_COUNT  = 2'd1,
    REG_ELEC_OFFSET = 2'd2,
    REG_TIMEOUT     = 2'd3
  } reg_idx_t;

  localparam logic [7:0] REQ_ID0 = 8'h02;
  localparam logic [7:0] REQ_ID1 = 8'h8A;
  localparam logic [7:0] REQ_ID2 = 8'h92;
  localparam logic [7:0] REQ_ID3 = 8'h1A;
  localparam logic [7:0] REQ_ID7 = 8'hBA;
  localparam logic [7:0] REQ_ID8 = 8'hC2;
  localparam logic [7:0] REQ_IDC = 8'h62;

  typedef struct packed {
    logic [2:0]  request_id;
    logic [7:0]  pair_count;
    logic [16:0] elec_offset;
    logic [15:0] timeout_ticks;
  } efpt_cfg_t;

  typedef struct packed {
    kind_t                       kind;
    logic [7:0]                  tx_byte;
    logic [7:0]                  control_field;
    logic [7:0]                  status_field;
    logic [PORT_POS_W-1:0]       single_turn;
    logic signed [15:0]          multi_turn;
    logic [7:0]                  encoder_id;
    logic [7:0]                  alarm;
    logic [7:0]                  frame_crc;
    logic signed [TOTAL_W-1:0]   total_position;
    logic [PORT_POS_W-1:0]       phase_angle;
  } efpt_result_t;

  function automatic logic [7:0] request_byte(input logic [2:0] id);
    logic [7:0] b;
    unique case (data_id_t'(id))
      ID_0:    b = REQ_ID0;
      ID_1:    b = REQ_ID1;
      ID_2:    b = REQ_ID2;
      ID_3:    b = REQ_ID3;
      ID_7:    b = REQ_ID7;
      ID_8:    b = REQ_ID8;
      ID_C:    b = REQ_IDC;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  // Reply length in bytes for each data ID.
  function automatic logic [CNT_W-1:0] expected_len(input logic [2:0] id);
    logic [CNT_W-1:0] n;
    unique case (data_id_t'(id))
      ID_2:    n = CNT_W'(4);
      ID_3:    n = CNT_W'(11);
      default: n = CNT_W'(6);
    endcase
    return n;
  endfunction

  function automatic logic [PORT_POS_W-1:0] pos_to_port(input logic [POS_W-1:0] p);
    logic [POS_W+PORT_POS_W-1:0] t;
    t = {{PORT_POS_W{1'b0}}, p};
    return t[PORT_POS_W-1:0];
  endfunction

endpackage

// ===== rtl/core/efpt_if.sv =====
// Handshake channels of the encoder frame position tracker.
// Input channel carries command and received byte; result channel the report.
// Depends on efpt_pkg.
interface efpt_in_if import efpt_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [1:0] cmd;
  logic [7:0] rx_byte;

  modport source(output valid, cmd, rx_byte, input ready);
  modport sink(input valid, cmd, rx_byte, output ready);
endinterface

interface efpt_out_if import efpt_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [1:0]               kind;
  logic [7:0]               tx_byte;
  logic [7:0]               control_field;
  logic [7:0]               status_field;
  logic [PORT_POS_W-1:0]    single_turn;
  logic signed [15:0]       multi_turn;
  logic [7:0]               encoder_id;
  logic [7:0]               alarm;
  logic [7:0]               frame_crc;
  logic signed [31:0]       total_position;
  logic [PORT_POS_W-1:0]    phase_angle;

  modport source(output valid, kind, tx_byte, control_field, status_field, single_turn,
                 multi_turn, encoder_id, alarm, frame_crc, total_position, phase_angle,
                 input ready);
  modport sink(input valid, kind, tx_byte, control_field, status_field, single_turn,
               multi_turn, encoder_id, alarm, frame_crc, total_position, phase_angle,
               output ready);
endinterface

// ===== rtl/core/efpt_engine.sv =====
// Protocol state, frame buffer, field decode, position unwrap and electrical angle.
// Updates its state once per step and presents the result of that step combinationally.
// Depends on efpt_pkg.
module efpt_engine
  import efpt_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         step,
  input  logic [1:0]   cmd,
  input  logic [7:0]   rx_byte,
  input  efpt_cfg_t    cfg,
  output logic         emit,
  output efpt_result_t res
);

  logic                waiting_r, waiting_nxt;
  logic                request_made_r, request_made_nxt;
  logic                raw_valid_r, raw_valid_nxt;
  logic [2:0]          active_id_r, active_id_nxt;
  logic [CNT_W-1:0]    byte_count_r, byte_count_nxt;
  logic [WAIT_W-1:0]   wait_ticks_r, wait_ticks_nxt;
  logic [7:0]          cf_r, cf_nxt, sf_r, sf_nxt, enid_r, enid_nxt;
  logic [7:0]          alarm_r, alarm_nxt, crc_r, crc_nxt;
  logic [15:0]         turns_r, turns_nxt;
  logic [POS_W-1:0]    single_r, single_nxt;
  logic [POS_W-1:0]    tracked_r, tracked_nxt;
  logic [POS_W-1:0]    last_raw_r, last_raw_nxt;
  logic [TOTAL_W-1:0]  accum_r, accum_nxt;

  logic [7:0]          frame_buf_r [FRAME_BYTES];
  logic                buf_we;

  logic [POS_W-1:0]    abs_pos;
  logic signed [POS_W+1:0] delta, delta_adj;
  logic [MUL_W-1:0]    mech, elec_diff;
  kind_t               kind;
  logic [7:0]          tx;

  assign abs_pos = POS_W'({frame_buf_r[4], frame_buf_r[3], frame_buf_r[2]});

  always_comb begin
    waiting_nxt      = waiting_r;
    request_made_nxt = request_made_r;
    raw_valid_nxt    = raw_valid_r;
    active_id_nxt    = active_id_r;
    byte_count_nxt   = byte_count_r;
    wait_ticks_nxt   = wait_ticks_r;
    cf_nxt           = cf_r;
    sf_nxt           = sf_r;
    enid_nxt         = enid_r;
    alarm_nxt        = alarm_r;
    crc_nxt          = crc_r;
    turns_nxt        = turns_r;
    single_nxt       = single_r;
    tracked_nxt      = tracked_r;
    last_raw_nxt     = last_raw_r;
    accum_nxt        = accum_r;
    buf_we           = 1'b0;
    emit             = 1'b0;
    kind             = KIND_REQUEST;
    tx               = 8'h00;
    delta            = '0;
    delta_adj        = '0;

    unique case (cmd)
      CMD_TICK: begin
        if (!waiting_r) begin
          wait_ticks_nxt = '0;
          // An undefined data ID polls nothing and leaves the block idle.
          if (cfg.request_id <= ID_C) begin
            active_id_nxt    = cfg.request_id;
            request_made_nxt = 1'b1;
            waiting_nxt      = 1'b1;
            emit             = 1'b1;
            kind             = KIND_REQUEST;
            tx               = request_byte(cfg.request_id);
          end
        end else begin
          wait_ticks_nxt = wait_ticks_r + WAIT_W'(1);
          if (wait_ticks_nxt > WAIT_W'(cfg.timeout_ticks)) begin
            waiting_nxt    = 1'b0;
            wait_ticks_nxt = '0;
            emit           = 1'b1;
            kind           = KIND_TIMEOUT;
          end
        end
      end
      CMD_BYTE: begin
        if (byte_count_r < CNT_W'(FRAME_BYTES)) begin
          buf_we         = 1'b1;
          byte_count_nxt = byte_count_r + CNT_W'(1);
        end
      end
      CMD_LINE_IDLE: begin
        emit = 1'b1;
        kind = KIND_SHORT;
        if (request_made_r && byte_count_r >= expected_len(active_id_r)) begin
          kind = KIND_DECODED;
          if (active_id_r != ID_7 && active_id_r != ID_8) begin
            cf_nxt = frame_buf_r[0];
            sf_nxt = frame_buf_r[1];
          end
          unique case (active_id_r)
            ID_0: begin
              single_nxt  = abs_pos;
              crc_nxt     = frame_buf_r[5];
              tracked_nxt = abs_pos;
            end
            ID_1: begin
              turns_nxt = {frame_buf_r[3], frame_buf_r[2]};
              crc_nxt   = frame_buf_r[5];
            end
            ID_2: begin
              enid_nxt = frame_buf_r[2];
              crc_nxt  = frame_buf_r[3];
            end
            ID_3: begin
              single_nxt  = abs_pos;
              enid_nxt    = frame_buf_r[5];
              turns_nxt   = {frame_buf_r[7], frame_buf_r[6]};
              alarm_nxt   = frame_buf_r[9];
              crc_nxt     = frame_buf_r[10];
              tracked_nxt = abs_pos;
            end
            ID_C: begin
              single_nxt = abs_pos;
              crc_nxt    = frame_buf_r[5];
            end
            default: begin
            end
          endcase

          // Unwrap: the step between readings is taken as the shorter way round.
          if (!raw_valid_r) begin
            accum_nxt     = {{(TOTAL_W-POS_W){1'b0}}, tracked_nxt};
            last_raw_nxt  = tracked_nxt;
            raw_valid_nxt = 1'b1;
          end else begin
            delta = $signed({2'b00, tracked_nxt}) - $signed({2'b00, last_raw_r});
            if (delta > $signed((POS_W+2)'(1 << (POS_W-1)))) begin
              delta_adj = delta - $signed((POS_W+2)'(1 << POS_W));
            end else if (delta < -$signed((POS_W+2)'(1 << (POS_W-1)))) begin
              delta_adj = delta + $signed((POS_W+2)'(1 << POS_W));
            end else begin
              delta_adj = delta;
            end
            accum_nxt    = accum_r + {{(TOTAL_W-POS_W-2){delta_adj[POS_W+1]}}, delta_adj};
            last_raw_nxt = tracked_nxt;
          end
        end
        waiting_nxt    = 1'b0;
        wait_ticks_nxt = '0;
        byte_count_nxt = '0;
      end
      default: begin
      end
    endcase
  end

  assign mech      = MUL_W'(tracked_nxt) * MUL_W'(cfg.pair_count);
  assign elec_diff = mech - MUL_W'(cfg.elec_offset);

  always_comb begin
    res.kind           = kind;
    res.tx_byte        = tx;
    res.control_field  = cf_nxt;
    res.status_field   = sf_nxt;
    res.single_turn    = pos_to_port(single_nxt);
    res.multi_turn     = $signed(turns_nxt);
    res.encoder_id     = enid_nxt;
    res.alarm          = alarm_nxt;
    res.frame_crc      = crc_nxt;
    res.total_position = $signed(accum_nxt);
    res.phase_angle    = pos_to_port(elec_diff[POS_W-1:0]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      waiting_r      <= 1'b0;
      request_made_r <= 1'b0;
      raw_valid_r    <= 1'b0;
      active_id_r    <= '0;
      byte_count_r   <= '0;
      wait_ticks_r   <= '0;
      cf_r           <= '0;
      sf_r           <= '0;
      enid_r         <= '0;
      alarm_r        <= '0;
      crc_r          <= '0;
      turns_r        <= '0;
      single_r       <= '0;
      tracked_r      <= '0;
      last_raw_r     <= '0;
      accum_r        <= '0;
    end else if (step) begin
      waiting_r      <= waiting_nxt;
      request_made_r <= request_made_nxt;
      raw_valid_r    <= raw_valid_nxt;
      active_id_r    <= active_id_nxt;
      byte_count_r   <= byte_count_nxt;
      wait_ticks_r   <= wait_ticks_nxt;
      cf_r           <= cf_nxt;
      sf_r           <= sf_nxt;
      enid_r         <= enid_nxt;
      alarm_r        <= alarm_nxt;
      crc_r          <= crc_nxt;
      turns_r        <= turns_nxt;
      single_r       <= single_nxt;
      tracked_r      <= tracked_nxt;
      last_raw_r     <= last_raw_nxt;
      accum_r        <= accum_nxt;
    end
  end

  // Only entries below the byte count are ever decoded, so the buffer needs no clearing.
  always_ff @(posedge clk) begin
    if (step && buf_we) begin
      frame_buf_r[byte_count_r[IDX_W-1:0]] <= rx_byte;
    end
  end

endmodule

// ===== rtl/core/encoder_frame_position_tracker.sv =====
// Top level of the encoder frame position tracker: handshake stages and APB registers.
// Depends on efpt_pkg, efpt_in_if, efpt_out_if and efpt_engine.
//
// The block polls an absolute encoder: ticks, received bytes and line-idle events arrive
// as transactions on the input channel, and request, decoded-frame, short-frame and
// timeout reports leave on the result channel. One transaction is accepted every clock
// cycle; each passes through an input register, and each that yields a report then
// passes through a result register, from which the report is offered on the result
// channel. The only thing that slows acceptance is a report held on the result channel
// while the sink is not ready. Registers (request_id, pair_count, elec_offset,
// timeout_ticks) sit at byte addresses 0, 4, 8 and 12 of the APB port. The user must
// write them only while the block is idle; the block itself does not enforce this.
module encoder_frame_position_tracker
  import efpt_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  efpt_in_if.sink      in_if,
  efpt_out_if.source   out_if,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [3:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  efpt_cfg_t     cfg_r;
  logic          cfg_we;
  reg_idx_t      cfg_idx;

  logic          stage_valid_r;
  logic [1:0]    stage_cmd_r;
  logic [7:0]    stage_byte_r;
  logic          advance;
  logic          in_accept;

  logic          emit;
  efpt_result_t  res;
  logic          out_valid_r;
  efpt_result_t  res_r;

  // APB registers.
  assign pready  = 1'b1;
  assign cfg_idx = reg_idx_t'(paddr[3:2]);
  assign cfg_we  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.request_id    <= 3'd0;
      cfg_r.pair_count    <= 8'd4;
      cfg_r.elec_offset   <= 17'd0;
      cfg_r.timeout_ticks <= 16'd10;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_REQUEST_ID:  cfg_r.request_id    <= pwdata[2:0];
        REG_PAIR_COUNT:  cfg_r.pair_count    <= pwdata[7:0];
        REG_ELEC_OFFSET: cfg_r.elec_offset   <= pwdata[16:0];
        REG_TIMEOUT:     cfg_r.timeout_ticks <= pwdata[15:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_REQUEST_ID:  prdata = {29'd0, cfg_r.request_id};
      REG_PAIR_COUNT:  prdata = {24'd0, cfg_r.pair_count};
      REG_ELEC_OFFSET: prdata = {15'd0, cfg_r.elec_offset};
      REG_TIMEOUT:     prdata = {16'd0, cfg_r.timeout_ticks};
      default:         prdata = 32'd0;
    endcase
  end

  // The input stage moves on whenever the result register is free or being emptied.
  assign advance     = stage_valid_r && (!out_valid_r || out_if.ready);
  assign in_if.ready = !stage_valid_r || advance;
  assign in_accept   = in_if.valid && in_if.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_valid_r <= 1'b0;
    end else if (in_accept) begin
      stage_valid_r <= 1'b1;
    end else if (advance) begin
      stage_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      stage_cmd_r  <= in_if.cmd;
      stage_byte_r <= in_if.rx_byte;
    end
  end

  efpt_engine u_engine (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (advance),
    .cmd     (stage_cmd_r),
    .rx_byte (stage_byte_r),
    .cfg     (cfg_r),
    .emit    (emit),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance && emit) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      res_r <= res;
    end
  end

  assign out_if.valid          = out_valid_r;
  assign out_if.kind           = res_r.kind;
  assign out_if.tx_byte        = res_r.tx_byte;
  assign out_if.control_field  = res_r.control_field;
  assign out_if.status_field   = res_r.status_field;
  assign out_if.single_turn    = res_r.single_turn;
  assign out_if.multi_turn     = res_r.multi_turn;
  assign out_if.encoder_id     = res_r.encoder_id;
  assign out_if.alarm          = res_r.alarm;
  assign out_if.frame_crc      = res_r.frame_crc;
  assign out_if.total_position = res_r.total_position;
  assign out_if.phase_angle    = res_r.phase_angle;

endmodule

// ===== rtl/core/efpt_checker.sv =====
// Port-level checks for the encoder frame position tracker, bound to the top level.
// Depends on efpt_pkg and encoder_frame_position_tracker.
module efpt_checker
  import efpt_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_kind,
  input logic [7:0]  out_tx_byte,
  input logic        psel,
  input logic        penable,
  input logic        pwrite,
  input logic [3:0]  paddr,
  input logic [31:0] pwdata,
  input logic [31:0] prdata
);

  // A report that is not taken must stay on offer.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result transaction withdrawn while stalled");

  // Only a request report carries a byte to transmit.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind != KIND_REQUEST |-> out_tx_byte == 8'h00)
    else $error("transmit byte set on a report that is not a request");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_REQUEST |->
      out_tx_byte == REQ_ID0 || out_tx_byte == REQ_ID1 || out_tx_byte == REQ_ID2 ||
      out_tx_byte == REQ_ID3 || out_tx_byte == REQ_ID7 || out_tx_byte == REQ_ID8 ||
      out_tx_byte == REQ_IDC)
    else $error("request report with an unknown command byte");

  // A pole pair count just written reads back at the same address.
  assert property (@(posedge clk) disable iff (!rst_n)
    psel && penable && pwrite && paddr[3:2] == REG_PAIR_COUNT |=>
      paddr[3:2] != REG_PAIR_COUNT || prdata[7:0] == $past(pwdata[7:0]))
    else $error("pole pair register does not read back the written value");

endmodule

bind encoder_frame_position_tracker efpt_checker u_efpt_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_if.valid),
  .out_ready   (out_if.ready),
  .out_kind    (out_if.kind),
  .out_tx_byte (out_if.tx_byte),
  .psel        (psel),
  .penable     (penable),
  .pwrite      (pwrite),
  .paddr       (paddr),
  .pwdata      (pwdata),
  .prdata      (prdata)
);
